/* sv/iragen_pkg.sv */
`default_nettype none

package iragen_pkg;

  // Field widths
  localparam int MODE_W     = 2;
  localparam int XY_W       = 12;
  localparam int DIM_W      = 13;
  localparam int LINE_W     = 15;
  localparam int PSZ_W      = 3;
  localparam int PIX_W      = 32;
  localparam int OUT_W      = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  // Register indexes
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_MODE      = 3'd0;
  localparam cfg_idx_t REG_DST_X     = 3'd1;
  localparam cfg_idx_t REG_DST_Y     = 3'd2;
  localparam cfg_idx_t REG_WIN_W     = 3'd3;
  localparam cfg_idx_t REG_WIN_H     = 3'd4;
  localparam cfg_idx_t REG_EXTENT    = 3'd5;
  localparam cfg_idx_t REG_LINE      = 3'd6;
  localparam cfg_idx_t REG_PIX_BYTES = 3'd7;

  // Rotation codes; the fourth code has no meaning and is flagged
  typedef logic [MODE_W-1:0] mode_t;
  localparam mode_t MODE_ROT90  = 2'd0;
  localparam mode_t MODE_ROT180 = 2'd1;
  localparam mode_t MODE_ROT270 = 2'd2;

  typedef struct packed {
    mode_t              mode;
    logic [XY_W-1:0]    dst_x;
    logic [XY_W-1:0]    dst_y;
    logic [DIM_W-1:0]   win_w;
    logic [DIM_W-1:0]   win_h;
    logic [DIM_W-1:0]   extent;
    logic [LINE_W-1:0]  line_bytes;
    logic [PSZ_W-1:0]   pix_bytes;
  } cfg_t;

endpackage

`default_nettype wire

/* sv/iragen_if.sv */
`default_nettype none

interface iragen_pix_if;
  import iragen_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             frame_start;
  modport source (output valid, pixel_value, frame_start, input ready);
  modport sink   (input valid, pixel_value, frame_start, output ready);
endinterface

interface iragen_addr_if;
  import iragen_pkg::*;
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] dest_offset;
  logic [PIX_W-1:0] pixel_out;
  logic             last_pixel;
  logic             out_of_range;
  modport source (output valid, dest_offset, pixel_out, last_pixel, out_of_range,
                  input ready);
  modport sink   (input valid, dest_offset, pixel_out, last_pixel, out_of_range,
                  output ready);
endinterface

interface iragen_cfg_if;
  import iragen_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/iragen_counter.sv */
`default_nettype none

module iragen_counter #(
  parameter int  MAX_DIM = 4096,
  localparam int CNT_W   = $clog2(MAX_DIM)
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire iragen_pkg::cfg_t     cfg,
  iragen_pix_if.sink                pix_in,
  input  wire logic                 en_b,
  output logic                      a_valid,
  output logic [CNT_W-1:0]          a_col,
  output logic [CNT_W-1:0]          a_row,
  output logic                      a_last,
  output logic [iragen_pkg::PIX_W-1:0] a_pixel
);
  import iragen_pkg::*;

  logic [CNT_W-1:0] column_count, row_count;
  logic [CNT_W-1:0] cur_col, cur_row;
  logic [CNT_W-1:0] column_count_next, row_count_next;
  logic [31:0]      w32, h32;
  logic [CNT_W:0]   w, h, col_inc, row_inc;
  logic             last_col, last_row, en_a, acc;

  // Stage A takes a beat when empty or when stage B takes its contents
  assign en_a         = !a_valid || en_b;
  assign pix_in.ready = en_a;
  assign acc          = pix_in.valid && en_a;

  // Clamp window size to 1..MAX_DIM
  always_comb begin
    if (cfg.win_w == '0) begin
      w32 = 32'd1;
    end else if ({19'd0, cfg.win_w} > 32'(MAX_DIM)) begin
      w32 = 32'(MAX_DIM);
    end else begin
      w32 = {19'd0, cfg.win_w};
    end
    if (cfg.win_h == '0) begin
      h32 = 32'd1;
    end else if ({19'd0, cfg.win_h} > 32'(MAX_DIM)) begin
      h32 = 32'(MAX_DIM);
    end else begin
      h32 = {19'd0, cfg.win_h};
    end
  end
  assign w = w32[CNT_W:0];
  assign h = h32[CNT_W:0];

  // Position of this pixel and position of the next
  assign cur_col  = pix_in.frame_start ? '0 : column_count;
  assign cur_row  = pix_in.frame_start ? '0 : row_count;
  assign col_inc  = {1'b0, cur_col} + (CNT_W+1)'(1);
  assign row_inc  = {1'b0, cur_row} + (CNT_W+1)'(1);
  assign last_col = col_inc >= w;
  assign last_row = row_inc >= h;

  always_comb begin
    if (last_col) begin
      column_count_next = '0;
      row_count_next    = last_row ? '0 : row_inc[CNT_W-1:0];
    end else begin
      column_count_next = col_inc[CNT_W-1:0];
      row_count_next    = cur_row;
    end
  end

  // Advance counters and load stage A
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      a_valid      <= 1'b0;
    end else begin
      if (acc) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
      end
      if (en_a) begin
        a_valid <= pix_in.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      a_col   <= cur_col;
      a_row   <= cur_row;
      a_last  <= last_col && last_row;
      a_pixel <= pix_in.pixel_value;
    end
  end

`ifndef SYNTHESIS
  a_wrap_after_last: assert property (@(posedge clk) disable iff (rst)
    acc && last_col && last_row |=> column_count == '0 && row_count == '0)
    else $error("counters did not wrap after last pixel");

  a_hold_stage_a: assert property (@(posedge clk) disable iff (rst)
    a_valid && !en_b |=> a_valid && $stable(a_col) && $stable(a_row))
    else $error("stage A lost a held pixel");
`endif

endmodule

`default_nettype wire

/* sv/iragen_calc.sv */
`default_nettype none

module iragen_calc #(
  parameter int CNT_W       = 12,
  parameter int OFFSET_BITS = 26
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire iragen_pkg::cfg_t        cfg,
  input  wire logic                    a_valid,
  input  wire logic [CNT_W-1:0]        a_col,
  input  wire logic [CNT_W-1:0]        a_row,
  input  wire logic                    a_last,
  input  wire logic [iragen_pkg::PIX_W-1:0] a_pixel,
  output logic                         en_b,
  iragen_addr_if.source                res
);
  import iragen_pkg::*;

  // Term width covers coordinate sums and differences with sign
  localparam int TW = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 3;
  localparam int AW = TW + LINE_W + 1;
  localparam int BW = TW + PSZ_W + 1;
  localparam int SW = AW + 2;

  logic signed [TW-1:0] xs, ys, es, cs, rs;
  logic signed [TW-1:0] t_x, t_ey, t_xn, t_ex, t_yr, ta, tb;
  logic signed [LINE_W:0] sl;
  logic signed [PSZ_W:0]  sp;
  logic signed [AW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic                   add_line, bad_mode;

  logic                   b_valid, b_last, b_bad, b_add;
  logic signed [AW-1:0]   b_pa;
  logic signed [BW-1:0]   b_pb;
  logic [PIX_W-1:0]       b_pixel;

  logic signed [SW-1:0]   sum;
  logic                   bad, en_c;

  // Pipeline enables
  assign en_c = !res.valid || res.ready;
  assign en_b = !b_valid || en_c;

  // Coordinate terms
  assign xs = $signed(TW'(cfg.dst_x));
  assign ys = $signed(TW'(cfg.dst_y));
  assign es = $signed(TW'(cfg.extent));
  assign cs = $signed(TW'(a_col));
  assign rs = $signed(TW'(a_row));
  assign sl = $signed({1'b0, cfg.line_bytes});
  assign sp = $signed({1'b0, cfg.pix_bytes});

  assign t_x  = xs + cs;
  assign t_ey = es - ys - rs - TW'(1);
  assign t_xn = -(xs + cs + TW'(1));
  assign t_ex = es - xs - cs - TW'(1);
  assign t_yr = ys + rs;

  // Pick line and pixel multiplicands for the rotation
  always_comb begin
    ta       = '0;
    tb       = '0;
    add_line = 1'b0;
    bad_mode = 1'b0;
    unique case (cfg.mode)
      MODE_ROT90: begin
        ta = t_x;
        tb = t_ey;
      end
      MODE_ROT180: begin
        ta       = t_ey;
        tb       = t_xn;
        add_line = 1'b1;
      end
      MODE_ROT270: begin
        ta = t_ex;
        tb = t_yr;
      end
      default: begin
        bad_mode = 1'b1;
      end
    endcase
  end

  assign mul_a = AW'(ta) * AW'(sl);
  assign mul_b = BW'(tb) * BW'(sp);

  // Stage B: register products
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (en_b) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && a_valid) begin
      b_pa    <= mul_a;
      b_pb    <= mul_b;
      b_add   <= add_line;
      b_bad   <= bad_mode;
      b_last  <= a_last;
      b_pixel <= a_pixel;
    end
  end

  // Sum and range check
  assign sum = SW'(b_pa) + SW'(b_pb)
             + (b_add ? $signed(SW'(cfg.line_bytes)) : SW'(0));
  assign bad = b_bad || sum[SW-1] || (|sum[SW-2:OFFSET_BITS]);

  // Stage C: result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en_c) begin
      res.valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && b_valid) begin
      res.dest_offset  <= bad ? '0 : sum[OUT_W-1:0];
      res.out_of_range <= bad;
      res.last_pixel   <= b_last;
      res.pixel_out    <= b_pixel;
    end
  end

`ifndef SYNTHESIS
  a_zero_when_flagged: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.out_of_range |-> res.dest_offset == '0)
    else $error("flagged offset is not zero");

  a_bad_mode_flagged: assert property (@(posedge clk) disable iff (rst)
    b_valid && en_c && b_bad |=> res.valid && res.out_of_range)
    else $error("undefined rotation code not flagged");
`endif

endmodule

`default_nettype wire

/* sv/image_rotate_address_generator.sv */
// Destination address generator for 90/180/270 degree window rotation.
// pix_in carries source pixels of the window in raster order; frame_start on
// a beat restarts the column and row counters at the window origin first.
// addr_out gives one beat per pixel: the byte offset in the destination
// buffer, the pixel itself, a last-pixel mark and an out-of-range flag (the
// offset then reads zero). An unused rotation code is always flagged.
// cfg_wr writes one register per beat and is always ready; write it only
// while no pixel is in flight.
// Three registered stages lie between input and output beat: counter stage,
// multiply stage, sum-and-check stage. One pixel is taken per cycle while
// addr_out.ready is high; each stage holds its beat while the next is full,
// so a stalled receiver fills the three stages before pix_in.ready drops.
// Reset clears the counters and the pipeline and sets the registers to
// 90 degrees, zero placement, a 1x1 window, extent 1, 4-byte lines and
// 4-byte pixels.
`default_nettype none

module image_rotate_address_generator #(
  parameter int MAX_DIM     = 4096,
  parameter int OFFSET_BITS = 26
) (
  input  wire logic     clk,
  input  wire logic     rst,
  iragen_cfg_if.sink    cfg_wr,
  iragen_pix_if.sink    pix_in,
  iragen_addr_if.source addr_out
);
  import iragen_pkg::*;

  localparam int CNT_W = $clog2(MAX_DIM);

  cfg_t             cfg;
  logic             a_valid, a_last, en_b;
  logic [CNT_W-1:0] a_col, a_row;
  logic [PIX_W-1:0] a_pixel;

  assign cfg_wr.ready = 1'b1;

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode       <= MODE_ROT90;
      cfg.dst_x      <= '0;
      cfg.dst_y      <= '0;
      cfg.win_w      <= DIM_W'(1);
      cfg.win_h      <= DIM_W'(1);
      cfg.extent     <= DIM_W'(1);
      cfg.line_bytes <= LINE_W'(4);
      cfg.pix_bytes  <= PSZ_W'(4);
    end else if (cfg_wr.valid) begin
      unique case (cfg_wr.index)
        REG_MODE:      cfg.mode       <= cfg_wr.data[MODE_W-1:0];
        REG_DST_X:     cfg.dst_x      <= cfg_wr.data[XY_W-1:0];
        REG_DST_Y:     cfg.dst_y      <= cfg_wr.data[XY_W-1:0];
        REG_WIN_W:     cfg.win_w      <= cfg_wr.data[DIM_W-1:0];
        REG_WIN_H:     cfg.win_h      <= cfg_wr.data[DIM_W-1:0];
        REG_EXTENT:    cfg.extent     <= cfg_wr.data[DIM_W-1:0];
        REG_LINE:      cfg.line_bytes <= cfg_wr.data[LINE_W-1:0];
        REG_PIX_BYTES: cfg.pix_bytes  <= cfg_wr.data[PSZ_W-1:0];
      endcase
    end
  end

  iragen_counter #(.MAX_DIM(MAX_DIM)) u_counter (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .pix_in  (pix_in),
    .en_b    (en_b),
    .a_valid (a_valid),
    .a_col   (a_col),
    .a_row   (a_row),
    .a_last  (a_last),
    .a_pixel (a_pixel)
  );

  iragen_calc #(.CNT_W(CNT_W), .OFFSET_BITS(OFFSET_BITS)) u_calc (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .a_valid (a_valid),
    .a_col   (a_col),
    .a_row   (a_row),
    .a_last  (a_last),
    .a_pixel (a_pixel),
    .en_b    (en_b),
    .res     (addr_out)
  );

endmodule

`default_nettype wire
